[rtl/core/cpnf_pkg.sv]
// Package for the colored page frame mapper.
// Holds shared constants, command and status codes, FSM states and payload types.
// No dependencies.
package cpnf_pkg;

    // Default depth of the color table.
    localparam int TABLE_DEPTH_DEF = 128;
    // Width of a page frame number.
    localparam int FRAME_BITS = 36;
    // Width of one stored color entry.
    localparam int COLOR_BITS = 7;
    // Width of the color_count_log2 register and its reset value.
    localparam int LOG2_W = 3;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd4;
    // Width of the appended color and of the entries_held field.
    localparam int CVAL_W = 8;
    localparam int HELD_W = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_XLATE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [CVAL_W-1:0]     color_value;
        logic [FRAME_BITS-1:0] page_frame;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_out;
        t_status               status;
        logic [HELD_W-1:0]     entries_held;
    } t_out_item;

endpackage

[rtl/core/cpnf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; width and depth come in as parameters.
module cpnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/colored_page_next_frame_top.sv]
// Top level of the colored page frame mapper.
// Depends on cpnf_pkg and instantiates cpnf_ram for the color table.

// A clear, an append or an unused command does not raise busy: its result is
// strobed in the next cycle, so such commands may follow each other in every
// cycle. A translation keeps busy high while it walks the N entries of the
// table (an empty table counts as one entry of color 0); the table RAM gives
// one entry per cycle and the walk stops at the first entry that is equal to
// or greater than the frame's color. The result is strobed in the cycle after
// the last compare, which is the first cycle a new command can
// be taken. Each result is present for exactly one cycle and must be captured
// then: the receiver cannot stall. The color count register may be written
// only while busy is low.
module colored_page_next_frame_top
    import cpnf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_cmd_item,
    input  logic              i_cfg_we,
    input  logic [LOG2_W-1:0] i_cfg_wdata,
    output logic              o_result_strobe,
    output t_out_item         o_result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LOG2_W-1:0]     r_log2;
    logic                  r_strobe, n_strobe;
    t_out_item             r_result, n_result;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [FRAME_BITS-1:0] r_wrap, n_wrap;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic [COLOR_BITS-1:0] r_cmask, n_cmask;
    logic [COLOR_BITS-1:0] r_first, n_first;

    logic                  accept;
    logic                  walk_done;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [COLOR_BITS-1:0] ram_rdata;
    logic [COLOR_BITS-1:0] cmask;
    logic [COLOR_BITS-1:0] entry;
    logic [COLOR_BITS-1:0] first;
    logic                  last;
    logic [CNT_W-1:0]      last_idx;

    assign accept = start && (r_state == S_IDLE);

    // Color table storage.
    cpnf_ram #(
        .WIDTH(COLOR_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(i_cmd_item.color_value[COLOR_BITS-1:0]),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Mask of the color field from the current color count.
    assign cmask = ~({COLOR_BITS{1'b1}} << r_log2);

    // Walk compare: an empty table behaves as a single entry of color 0.
    assign entry    = (r_count == '0) ? '0 : ram_rdata;
    assign first    = (r_idx == '0) ? entry : r_first;
    assign last_idx = (r_count == '0) ? '0 : r_count - CNT_W'(1);
    assign last     = (CNT_W'(r_idx) == last_idx);

    // Replace the color field of a frame with the given entry.
    function automatic logic [FRAME_BITS-1:0] put_color(
        input logic [FRAME_BITS-1:0] frame,
        input logic [COLOR_BITS-1:0] mask,
        input logic [COLOR_BITS-1:0] color
    );
        logic [FRAME_BITS-1:0] wide_mask;
        wide_mask = FRAME_BITS'(mask);
        return (frame & ~wide_mask) | (FRAME_BITS'(color) & wide_mask);
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd_item.cmd == CMD_XLATE) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_result  = r_result;
        n_idx     = r_idx;
        n_frame   = r_frame;
        n_wrap    = r_wrap;
        n_color   = r_color;
        n_cmask   = r_cmask;
        n_first   = r_first;
        ram_we    = 1'b0;
        ram_raddr = r_idx + IDX_W'(1);
        walk_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (accept) begin
                    n_result.frame_out = '0;
                    n_result.status    = ST_OK;
                    case (i_cmd_item.cmd)
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                        end
                        CMD_APPEND: begin
                            n_strobe = 1'b1;
                            if ((i_cmd_item.color_value >> r_log2) != '0) begin
                                n_result.status = ST_RANGE;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_XLATE: begin
                            n_idx   = '0;
                            n_frame = i_cmd_item.page_frame;
                            n_wrap  = i_cmd_item.page_frame
                                      + (FRAME_BITS'(1) << r_log2);
                            n_color = i_cmd_item.page_frame[COLOR_BITS-1:0] & cmask;
                            n_cmask = cmask;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                    n_result.entries_held = HELD_W'(n_count);
                end
            end
            S_WALK: begin
                n_first = first;
                n_idx   = r_idx + IDX_W'(1);
                if (r_color == entry) begin
                    walk_done          = 1'b1;
                    n_result.frame_out = r_frame;
                end else if (r_color < entry) begin
                    walk_done          = 1'b1;
                    n_result.frame_out = put_color(r_frame, r_cmask, entry);
                end else if (last) begin
                    walk_done          = 1'b1;
                    n_result.frame_out = put_color(r_wrap, r_cmask, first);
                end
                if (walk_done) begin
                    n_strobe              = 1'b1;
                    n_result.status       = ST_OK;
                    n_result.entries_held = HELD_W'(r_count);
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_log2   <= LOG2_RESET;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_idx    <= n_idx;
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_frame  <= n_frame;
        r_wrap   <= n_wrap;
        r_color  <= n_color;
        r_cmask  <= n_cmask;
        r_first  <= n_first;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

[rtl/core/cpnf_checker.sv]
// Port-level checker for the colored page frame mapper, bound to the top level.
// Depends on cpnf_pkg and on the ports of colored_page_next_frame_top.
module cpnf_checker
    import cpnf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_cmd_item,
    input logic      o_result_strobe,
    input t_out_item o_result
);

    // A command other than a translation gives its result in the next cycle.
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd_item.cmd != CMD_XLATE) |=> o_result_strobe)
        else $error("short command gave no result transfer in the next cycle");

    // A result is only shown once the walk is over.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result transfer while busy");

    // Rejected appends carry no frame.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.status != ST_OK) |-> (o_result.frame_out == '0))
        else $error("rejected append with a nonzero frame");

    // The table never reports more entries than it holds.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_result.entries_held <= HELD_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

endmodule

bind colored_page_next_frame_top cpnf_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_cpnf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd_item     (i_cmd_item),
    .o_result_strobe(o_result_strobe),
    .o_result       (o_result)
);

[tb/cpnf_checker.sv]
// Checker for the colored page frame mapper: watches commands, register writes and results.
// Predicts each result from its own copy of the color table and register, compares field by field.
// Depends on cpnf_pkg.
`timescale 1ns / 100ps

module cpnf_tb_checker
    import cpnf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_in_item          i_cmd_item,
    input  logic              i_cfg_we,
    input  logic [LOG2_W-1:0] i_cfg_wdata,
    input  logic              i_result_strobe,
    input  t_out_item         i_result,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int IDX_W = $clog2(TABLE_DEPTH_DEF);

    // Shadow copy of the mapper state.
    logic [COLOR_BITS-1:0] color_list [TABLE_DEPTH_DEF];
    logic [HELD_W-1:0]     held_count;
    logic [LOG2_W-1:0]     colors_log2;

    t_out_item expected_results [$];
    int        fails = 0;

    // Nearest frame whose color is in the table, walking entries in stored order.
    function automatic logic [FRAME_BITS-1:0] nearest_colored_frame(
        input logic [FRAME_BITS-1:0] frame
    );
        logic [FRAME_BITS-1:0] span;
        logic [FRAME_BITS-1:0] cmask;
        logic [FRAME_BITS-1:0] bumped;
        logic [COLOR_BITS-1:0] color;
        logic [COLOR_BITS-1:0] entry;
        logic [COLOR_BITS-1:0] first;
        span  = FRAME_BITS'(1) << colors_log2;
        cmask = span - FRAME_BITS'(1);
        color = frame[COLOR_BITS-1:0] & cmask[COLOR_BITS-1:0];
        for (int i = 0; i < int'(held_count); i++) begin
            entry = color_list[i];
            if (color == entry)
                return frame;
            // Entries may be stale from a larger color count, so only the
            // bits inside the color field are inserted.
            if (color < entry)
                return (frame & ~cmask) | (FRAME_BITS'(entry) & cmask);
        end
        // An empty table behaves as the single color zero.
        if (held_count == '0) begin
            if (color == '0)
                return frame;
            first = '0;
        end else begin
            first = color_list[0];
        end
        bumped = frame + span;
        return (bumped & ~cmask) | (FRAME_BITS'(first) & cmask);
    endfunction

    // Applies one command to the shadow state and returns the result it should give.
    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item         res;
        logic [CVAL_W:0]   color_span;
        res = '0;
        case (item.cmd)
            CMD_CLEAR: begin
                held_count = '0;
            end
            CMD_APPEND: begin
                color_span = (CVAL_W+1)'(1) << colors_log2;
                // The range check comes before the full check.
                if ({1'b0, item.color_value} >= color_span) begin
                    res.status = ST_RANGE;
                end else if (int'(held_count) >= TABLE_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    color_list[held_count[IDX_W-1:0]] = item.color_value[COLOR_BITS-1:0];
                    held_count = held_count + 1'b1;
                end
            end
            CMD_XLATE: begin
                res.frame_out = nearest_colored_frame(item.page_frame);
            end
            default: begin
                // The unused command changes nothing.
            end
        endcase
        res.entries_held = held_count;
        return res;
    endfunction

    // Results are compared before the command of the same edge is predicted,
    // since a result always belongs to an earlier transfer.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            held_count  = '0;
            colors_log2 = LOG2_RESET;
            expected_results.delete();
        end else begin
            if (i_result_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: frame_out %h status %0d",
                           i_result.frame_out, i_result.status);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.frame_out !== want.frame_out) begin
                        $error("frame_out: expected %h, actual %h",
                               want.frame_out, i_result.frame_out);
                        fails++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_result.status);
                        fails++;
                    end
                    if (i_result.entries_held !== want.entries_held) begin
                        $error("entries_held: expected %0d, actual %0d",
                               want.entries_held, i_result.entries_held);
                        fails++;
                    end
                end
            end
            if (i_cfg_we)
                colors_log2 = i_cfg_wdata;
            if (i_start && !i_busy)
                expected_results.push_back(predict_result(i_cmd_item));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the colored page frame mapper: clock, reset, stimulus and verdict.
// Depends on cpnf_pkg, colored_page_next_frame_top and cpnf_tb_checker.
`timescale 1ns / 100ps

module tb_top;
    import cpnf_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 166;
    localparam int         MAX_GAP     = 30;
    localparam int         DRAIN_WAIT  = 200;
    localparam int         STALL_LIMIT = 5000;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    t_in_item          cmd_item  = '0;
    logic              cfg_we    = 1'b0;
    logic [LOG2_W-1:0] cfg_wdata = '0;
    logic              busy;
    logic              result_strobe;
    t_out_item         result;
    int                fail_count;
    int                pending;

    int                idle_pct   = 0;
    int                items_sent = 0;
    int                stall_cycles = 0;
    logic [LOG2_W-1:0] cur_log2   = LOG2_RESET;
    logic [LOG2_W-1:0] phase_log2 [PHASES] = '{3'd7, 3'd1, 3'd3, 3'd0, 3'd6, 3'd2, 3'd5, 3'd4};
    int                phase_idle [4] = '{0, 69, 0, 17};

    always #5 i_clk = ~i_clk;

    colored_page_next_frame_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd_item      (cmd_item),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_result_strobe (result_strobe),
        .o_result        (result)
    );

    cpnf_tb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd_item      (cmd_item),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_result_strobe (result_strobe),
        .i_result        (result),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || result_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [FRAME_BITS-1:0] rand_frame();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[FRAME_BITS-1:0];
    endfunction

    // Random frame with the given color in its low bits.
    function automatic logic [FRAME_BITS-1:0] frame_with_color(input logic [COLOR_BITS-1:0] c);
        logic [FRAME_BITS-1:0] cmask;
        cmask = (FRAME_BITS'(1) << cur_log2) - FRAME_BITS'(1);
        return (rand_frame() & ~cmask) | (FRAME_BITS'(c) & cmask);
    endfunction

    // One command transfer, after a random idle gap; start stays high between
    // back-to-back transfers.
    task automatic send_item(input logic [1:0] code, input logic [CVAL_W-1:0] cval,
                             input logic [FRAME_BITS-1:0] frame);
        t_in_item next;
        int       gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        next.cmd         = t_cmd'(code);
        next.color_value = cval;
        next.page_frame  = frame;
        start    <= 1'b1;
        cmd_item <= next;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int phase_start;
        int seq_no;
        int kind;
        int ncol;
        int cur;
        int k;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset color count of sixteen colors.
        send_item(CMD_XLATE, 8'h00, '0);
        send_item(CMD_XLATE, 8'hFF, '1);
        send_item(CMD_APPEND, 8'd16, rand_frame());
        send_item(CMD_APPEND, 8'hFF, '1);
        send_item(CMD_APPEND, 8'd2, rand_frame());
        send_item(CMD_APPEND, 8'd9, rand_frame());
        send_item(CMD_APPEND, 8'd12, rand_frame());
        send_item(CMD_APPEND, 8'd9, rand_frame());
        send_item(CMD_XLATE, 8'hA5, frame_with_color(7'd2));
        send_item(CMD_XLATE, 8'h5A, frame_with_color(7'd0));
        send_item(CMD_XLATE, 8'h00, frame_with_color(7'd5));
        send_item(CMD_XLATE, 8'h00, frame_with_color(7'd13));
        send_item(CMD_XLATE, 8'h00, '1);
        send_item(CMD_XLATE, 8'h00, 36'h0_0000_000F);
        send_item(CMD_UNUSED, 8'hFF, '1);
        send_item(CMD_UNUSED, CVAL_W'($urandom), rand_frame());
        send_item(CMD_CLEAR, 8'hFF, '1);
        send_item(CMD_XLATE, 8'h00, frame_with_color(7'd6));
        send_item(CMD_APPEND, 8'd0, '0);
        send_item(CMD_APPEND, 8'd15, '0);
        send_item(CMD_XLATE, 8'h00, frame_with_color(7'd15));
        send_item(CMD_XLATE, 8'h00, frame_with_color(7'd1));

        // Random phases, each under its own color count and one of four idle patterns.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_log2[p];
            cur_log2   = phase_log2[p];
            @(posedge i_clk);
            cfg_we    <= 1'b0;
            idle_pct   = phase_idle[p % 4];
            ncol       = 1 << cur_log2;
            phase_start = items_sent;
            seq_no     = 0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // Start each phase with lookups against stale entries.
                if (seq_no == 0)
                    kind = 1;
                else if (seq_no == 1 && p == 0)
                    kind = 0;
                else begin
                    k    = $urandom_range(99);
                    kind = (k < 4) ? 0 : (k < 22) ? 1 : (k < 32) ? 2 : 3;
                end
                case (kind)
                    0: begin
                        // Fill the table past its depth, then look up.
                        send_item(CMD_CLEAR, CVAL_W'($urandom), rand_frame());
                        for (int j = 0; j < TABLE_DEPTH_DEF + 2; j++)
                            send_item(CMD_APPEND, CVAL_W'($urandom_range(0, ncol - 1)),
                                      rand_frame());
                        for (int j = 0; j < 4; j++)
                            send_item(CMD_XLATE, CVAL_W'($urandom), rand_frame());
                    end
                    1: begin
                        k = $urandom_range(3, 8);
                        for (int j = 0; j < k; j++)
                            send_item(CMD_XLATE, CVAL_W'($urandom), rand_frame());
                    end
                    2: begin
                        k = $urandom_range(1, 3);
                        for (int j = 0; j < k; j++)
                            send_item(2'($urandom_range(0, 3)), CVAL_W'($urandom),
                                      rand_frame());
                    end
                    default: begin
                        // Clear, load a mostly ascending color list, then translate.
                        send_item(CMD_CLEAR, CVAL_W'($urandom), rand_frame());
                        k   = $urandom_range(1, 8);
                        cur = $urandom_range(0, ncol - 1) / 4;
                        for (int j = 0; j < k; j++) begin
                            if ($urandom_range(99) < 20)
                                send_item(CMD_APPEND, CVAL_W'($urandom), rand_frame());
                            else if (cur < ncol)
                                send_item(CMD_APPEND, CVAL_W'(cur), rand_frame());
                            else
                                send_item(CMD_APPEND, CVAL_W'($urandom_range(0, ncol - 1)),
                                          rand_frame());
                            cur = cur + $urandom_range(1, ncol / 4 + 1);
                        end
                        k = $urandom_range(2, 10);
                        for (int j = 0; j < k; j++)
                            send_item(CMD_XLATE, CVAL_W'($urandom), rand_frame());
                    end
                endcase
                seq_no++;
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
